### design/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the button press classifier with auto-off.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // Held ticks before a long press fires (repeats every LONG_HOLD+1 ticks)
    localparam logic [3:0] LONG_HOLD       = 4'd10;
    // Top value of the subsecond counter; a second is SUBSECOND_TICKS+1 ticks
    localparam logic [3:0] SUBSECOND_TICKS = 4'd10;
    // Top value of the window counter; a window is WINDOW_TICKS+1 ticks
    localparam logic [6:0] WINDOW_TICKS    = 7'd100;
    // Top value of the measure counter; a pulse every MEASURE_DIV+1 seconds
    localparam logic [1:0] MEASURE_DIV     = 2'd2;

    // Events found by one button lane on one tick
    typedef struct packed {
        logic press_short;
        logic press_long;
    } bpc_lane_ev_t;

    // Events found by the timebase on one tick
    typedef struct packed {
        logic auto_off_expired;
        logic measure_tick;
        logic window_end;
    } bpc_timer_ev_t;

    // One result transaction
    typedef struct packed {
        bpc_lane_ev_t  main_ev;
        bpc_lane_ev_t  up_ev;
        bpc_lane_ev_t  down_ev;
        bpc_timer_ev_t timer_ev;
    } bpc_result_t;

endpackage

### design/button_press_classifier_with_autooff_unit.sv
// ----------------------------------------------------------------------------
// button_press_classifier_with_autooff_unit
// Short/long press classifier for three buttons with an auto-off timebase.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid / in_stall | main_pressed up_pressed down_pressed
//           |                     | clear_auto_off
//  out      | out_valid/out_stall | main_/up_/down_ short,long; auto_off_expired
//           |                     | measure_tick window_end
//  cfg      | cfg_wr_en           | cfg_wr_data (auto-off limit, seconds)
//
//  One transaction per cycle while in_stall is low; the lane and timebase
//  logic is combinational and each result is registered at the output.
//  Three button lanes run side by side; the up/down cross-clear chain is the
//  longest path. A skid register absorbs one result while out_stall is high;
//  in_stall rises only once both output stages are full.
//  Reset clears all counters, lane state, the limit and both output stages.
// ----------------------------------------------------------------------------
module button_press_classifier_with_autooff_unit
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        main_pressed,
    input  logic        up_pressed,
    input  logic        down_pressed,
    input  logic        clear_auto_off,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        main_short,
    output logic        main_long,
    output logic        up_short,
    output logic        up_long,
    output logic        down_short,
    output logic        down_long,
    output logic        auto_off_expired,
    output logic        measure_tick,
    output logic        window_end,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic          tick;
    logic          buf_full;
    bpc_lane_ev_t  main_ev;
    bpc_lane_ev_t  up_ev;
    bpc_lane_ev_t  down_ev;
    bpc_timer_ev_t timer_ev;
    bpc_result_t   result;
    bpc_result_t   out_data;

    assign in_stall = buf_full;
    assign tick     = in_valid && !buf_full;

    // Main lane: a long press clears only its own hold count
    bpc_lane u_main_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .level      (main_pressed),
        .clr_before (1'b0),
        .clr_after  (1'b0),
        .ev         (main_ev)
    );

    // Up lane: cleared after its own or the down lane's long press
    bpc_lane u_up_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .level      (up_pressed),
        .clr_before (1'b0),
        .clr_after  (up_ev.press_long || down_ev.press_long),
        .ev         (up_ev)
    );

    // Down lane: sees the up lane's clear before it evaluates
    bpc_lane u_down_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .level      (down_pressed),
        .clr_before (up_ev.press_long),
        .clr_after  (down_ev.press_long),
        .ev         (down_ev)
    );

    bpc_timer u_timer (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .clear_auto_off (clear_auto_off),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .ev             (timer_ev)
    );

    // Merge lane and timebase events into one result
    always_comb
    begin
        result.main_ev  = main_ev;
        result.up_ev    = up_ev;
        result.down_ev  = down_ev;
        result.timer_ev = timer_ev;
    end

    bpc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tick),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign main_short       = out_data.main_ev.press_short;
    assign main_long        = out_data.main_ev.press_long;
    assign up_short         = out_data.up_ev.press_short;
    assign up_long          = out_data.up_ev.press_long;
    assign down_short       = out_data.down_ev.press_short;
    assign down_long        = out_data.down_ev.press_long;
    assign auto_off_expired = out_data.timer_ev.auto_off_expired;
    assign measure_tick     = out_data.timer_ev.measure_tick;
    assign window_end       = out_data.timer_ev.window_end;

`ifndef NO_ASSERTIONS
    // Input is only held off while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
    else $error("input stalled with empty output");

    // Up and down long presses exclude each other in one tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(up_long && down_long))
    else $error("up and down long press in one result");

    // A lane never reports short and long on the same tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((main_short && main_long) || (up_short && up_long)
                        || (down_short && down_long)))
    else $error("short and long press in one lane result");
`endif

endmodule

### design/bpc_lane.sv
// ----------------------------------------------------------------------------
// bpc_lane
// One button lane: edge arming, short press on release, long press on hold.
// ----------------------------------------------------------------------------
module bpc_lane
    import bpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         tick,
    input  logic         level,
    input  logic         clr_before,
    input  logic         clr_after,
    output bpc_lane_ev_t ev
);

    logic       last_reg;
    logic       last_next;
    logic       armed_reg;
    logic       armed_next;
    logic       armed_cls;
    logic [3:0] hold_reg;
    logic [3:0] hold_next;
    logic [3:0] hold_cls;

    // Classify this tick and compute the lane state before any late clear
    always_comb
    begin
        logic       armed_eff;
        logic [3:0] hold_eff;
        armed_eff      = clr_before ? 1'b0 : armed_reg;
        hold_eff       = clr_before ? 4'd0 : hold_reg;
        armed_cls      = armed_eff;
        hold_cls       = 4'd0;
        ev.press_short = 1'b0;
        ev.press_long  = 1'b0;
        if (level != last_reg)
        begin
            if (level)
            begin
                armed_cls = 1'b1;
            end
            else if (armed_eff)
            begin
                armed_cls      = 1'b0;
                ev.press_short = 1'b1;
            end
        end
        else if (level)
        begin
            if (hold_eff < LONG_HOLD)
            begin
                hold_cls = hold_eff + 4'd1;
            end
            else
            begin
                ev.press_long = 1'b1;
            end
        end
        last_next = level;
    end

    // Drop arm and hold after a long press on the up/down pair
    assign armed_next = clr_after ? 1'b0 : armed_cls;
    assign hold_next  = clr_after ? 4'd0 : hold_cls;

    // Advance the lane state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            armed_reg <= 1'b0;
            hold_reg  <= 4'd0;
        end
        else if (tick)
        begin
            last_reg  <= last_next;
            armed_reg <= armed_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

### design/bpc_timer.sv
// ----------------------------------------------------------------------------
// bpc_timer
// Timebase: seconds divider, auto-off countdown, measure and window pulses.
// ----------------------------------------------------------------------------
module bpc_timer
    import bpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tick,
    input  logic          clear_auto_off,
    input  logic          cfg_wr_en,
    input  logic [15:0]   cfg_wr_data,
    output bpc_timer_ev_t ev
);

    logic [15:0] limit_reg;
    logic [3:0]  sub_reg;
    logic [3:0]  sub_next;
    logic [15:0] sec_reg;
    logic [15:0] sec_next;
    logic [1:0]  meas_reg;
    logic [1:0]  meas_next;
    logic [6:0]  win_reg;
    logic [6:0]  win_next;

    // Compute the next counters and this tick's pulses
    always_comb
    begin
        logic [15:0] sec_base;
        logic [15:0] sec_inc;
        sec_base            = clear_auto_off ? 16'd0 : sec_reg;
        sec_inc             = sec_base + 16'd1;
        ev.auto_off_expired = 1'b0;
        ev.measure_tick     = 1'b0;
        ev.window_end       = 1'b0;
        sec_next            = sec_base;
        meas_next           = meas_reg;

        if (win_reg < WINDOW_TICKS)
        begin
            win_next = win_reg + 7'd1;
        end
        else
        begin
            win_next      = 7'd0;
            ev.window_end = 1'b1;
        end

        if (sub_reg < SUBSECOND_TICKS)
        begin
            sub_next = sub_reg + 4'd1;
        end
        else
        begin
            sub_next = 4'd0;
            if ((limit_reg != 16'd0) && (sec_inc >= limit_reg))
            begin
                sec_next            = 16'd0;
                ev.auto_off_expired = 1'b1;
            end
            else
            begin
                sec_next = sec_inc;
            end
            if (meas_reg < MEASURE_DIV)
            begin
                meas_next = meas_reg + 2'd1;
            end
            else
            begin
                meas_next       = 2'd0;
                ev.measure_tick = 1'b1;
            end
        end
    end

    // Hold the limit and restart the seconds count on a limit write; advance the counters on each tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 16'd0;
            sub_reg   <= 4'd0;
            sec_reg   <= 16'd0;
            meas_reg  <= 2'd0;
            win_reg   <= 7'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
                sec_reg   <= 16'd0;
            end
            else if (tick)
            begin
                sec_reg <= sec_next;
            end
            if (tick)
            begin
                sub_reg  <= sub_next;
                meas_reg <= meas_next;
                win_reg  <= win_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Window counter wraps to zero after its last tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick && (win_reg == WINDOW_TICKS)) |=> (win_reg == 7'd0))
    else $error("window counter did not wrap");

    // An expiry pulse only comes with a nonzero limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick && ev.auto_off_expired) |-> (limit_reg != 16'd0))
    else $error("auto-off expired with limit zero");

    // A seconds count at or past a nonzero limit never survives a wrap
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick && !cfg_wr_en && (sub_reg == SUBSECOND_TICKS) && (limit_reg != 16'd0))
        |=> (sec_reg < $past(limit_reg)))
    else $error("seconds count left at or past limit");
`endif

endmodule

### design/bpc_out_buf.sv
// ----------------------------------------------------------------------------
// bpc_out_buf
// Output stage: output register plus skid register for result transactions.
// ----------------------------------------------------------------------------
module bpc_out_buf
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bpc_result_t push_data,
    output logic        full,
    output logic        out_valid,
    input  logic        out_stall,
    output bpc_result_t out_data
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    bpc_result_t out_data_reg;
    bpc_result_t skid_data_reg;
    logic        pop;

    assign pop       = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Next occupancy of the two stages
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Move payload: skid drains into the output, new data fills the free stage
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule
